@@ rtl/core/lrmp_pkg.sv @@
// lrmp_pkg: shared constants for the matrix power block
// no dependencies
`default_nettype none
package lrmp_pkg;
    localparam logic [29:0] MODULUS = 30'd1000000007;
    localparam int VAL_W = 30;
    // floor(2^60 / p) for the reciprocal reduction
    localparam logic [30:0] RECIP_MU = 31'(64'd1152921504606846976 / 64'd1000000007);
endpackage
`default_nettype wire

@@ rtl/core/lrmp_mac.sv @@
// lrmp_mac: modular multiply-accumulate unit, acc + a*b mod p
// five-stage pipeline with reduction by a precomputed reciprocal; depends on lrmp_pkg
`default_nettype none
module lrmp_mac
    import lrmp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [VAL_W-1:0] a,
    input  wire logic [VAL_W-1:0] b,
    input  wire logic [VAL_W-1:0] acc,
    output logic                  done,
    output logic [VAL_W-1:0]      result
);
    localparam logic [31:0] MOD_X1 = {2'b00, MODULUS};
    localparam logic [31:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

    logic [3:0]       stage_reg, stage_next;
    logic             done_reg, done_next;
    logic [59:0]      prod_reg, prod_next;
    logic [30:0]      quot_reg, quot_next;
    logic [31:0]      low2_reg, low2_next;
    logic [31:0]      low3_reg, low3_next;
    logic [31:0]      qp_reg, qp_next;
    logic [VAL_W-1:0] red_reg, red_next;
    logic [VAL_W-1:0] acc1_reg, acc1_next;
    logic [VAL_W-1:0] acc2_reg, acc2_next;
    logic [VAL_W-1:0] acc3_reg, acc3_next;
    logic [VAL_W-1:0] acc4_reg, acc4_next;
    logic [VAL_W-1:0] res_reg, res_next;
    logic [61:0]      est;
    logic [31:0]      rem;
    logic [30:0]      sum;

    always_comb
    begin
        stage_next = {stage_reg[2:0], start};
        done_next  = stage_reg[3];
        // product
        prod_next  = 60'(a) * 60'(b);
        acc1_next  = acc;
        // quotient estimate, at most two short
        est        = 62'(prod_reg[59:29]) * 62'(RECIP_MU);
        quot_next  = 31'(est >> 31);
        low2_next  = prod_reg[31:0];
        acc2_next  = acc1_reg;
        // low bits of quotient times p
        qp_next    = 32'(quot_reg) * 32'(MODULUS);
        low3_next  = low2_reg;
        acc3_next  = acc2_reg;
        // remainder below 3p
        rem        = low3_reg - qp_reg;
        if (rem >= MOD_X2)
            red_next = VAL_W'(rem - MOD_X2);
        else if (rem >= MOD_X1)
            red_next = VAL_W'(rem - MOD_X1);
        else
            red_next = VAL_W'(rem);
        acc4_next  = acc3_reg;
        // accumulate
        sum        = {1'b0, red_reg} + {1'b0, acc4_reg};
        res_next   = (sum >= {1'b0, MODULUS}) ? VAL_W'(sum - {1'b0, MODULUS})
                                              : VAL_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        low2_reg <= low2_next;
        low3_reg <= low3_next;
        qp_reg   <= qp_next;
        red_reg  <= red_next;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        acc3_reg <= acc3_next;
        acc4_reg <= acc4_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

@@ rtl/core/linear_recurrence_matrix_power_mod.sv @@
// linear_recurrence_matrix_power_mod: entry (0,0) of K^n mod 1000000007
// sequence: init fills the base and accumulator matrices, then per exponent bit a check,
// for a set bit a multiply of the accumulator by the base, and a squaring of the base;
// every multiply-accumulate runs on the shared unit; out_valid rises in the output state
// after the last check; one item at a time, in_stall high while busy; async active-low reset clears control
// depends on lrmp_pkg and lrmp_mac
`default_nettype none
module linear_recurrence_matrix_power_mod
    import lrmp_pkg::*;
#(
    parameter int MAX_ORDER     = 16,
    parameter int EXPONENT_BITS = 60
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [4:0]               cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [59:0]              exponent,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [VAL_W-1:0]              count_mod_p
);
    localparam int IW    = $clog2(MAX_ORDER);
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = 2 * IW;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CHECK, S_RD, S_RDW, S_MAC, S_WR, S_CPR, S_CPW, S_OUT
    } state_t;

    state_t state_reg;
    logic [4:0] order_reg;
    logic [EXPONENT_BITS-1:0] exp_reg;
    logic [CW-1:0] m_reg;
    logic [IW-1:0] r_reg, c_reg, t_reg;
    logic mul_acc_reg;                 // 1: acc = acc*base, 0: base = base*base
    logic [VAL_W-1:0] sum_reg, res_reg;
    logic out_valid_reg;

    logic [VAL_W-1:0] base_mem [DEPTH];
    logic [VAL_W-1:0] accm_mem [DEPTH];
    logic [VAL_W-1:0] scr_mem  [DEPTH];
    logic [VAL_W-1:0] base_rd_a, base_rd_b, accm_rd, scr_rd;

    logic mac_start, mac_done;
    logic [VAL_W-1:0] mac_res;
    logic [4:0] m_sat5;
    logic [CW-1:0] m_sat;
    logic [IW-1:0] m_last;
    logic [AW-1:0] a_addr, b_addr, rc_addr;
    logic last_t, last_c, last_r;
    logic base_we, accm_we;
    logic [VAL_W-1:0] init_base, init_accm;

    always_comb
    begin
        if (order_reg < 5'd2)
            m_sat5 = 5'd2;
        else if (32'(order_reg) > MAX_ORDER)
            m_sat5 = 5'(MAX_ORDER);
        else
            m_sat5 = order_reg;
    end
    assign m_sat  = CW'(m_sat5);
    assign m_last = IW'(m_reg - CW'(1));
    assign a_addr  = {r_reg, t_reg};
    assign b_addr  = {t_reg, c_reg};
    assign rc_addr = {r_reg, c_reg};
    assign last_t = (t_reg == m_last);
    assign last_c = (c_reg == m_last);
    assign last_r = (r_reg == m_last);

    always_comb
    begin
        init_base = '0;
        if (r_reg != '0 && CW'(c_reg) + CW'(1) == CW'(r_reg))
            init_base = VAL_W'(1);
        if (r_reg == '0 && (c_reg == '0 || c_reg == m_last))
            init_base = VAL_W'(1);
        init_accm = (r_reg == c_reg) ? VAL_W'(1) : '0;
    end

    assign base_we = (state_reg == S_INIT) || (state_reg == S_CPW && !mul_acc_reg);
    assign accm_we = (state_reg == S_INIT) || (state_reg == S_CPW &&  mul_acc_reg);

    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[rc_addr] <= (state_reg == S_INIT) ? init_base : scr_rd;
        if (accm_we)
            accm_mem[rc_addr] <= (state_reg == S_INIT) ? init_accm : scr_rd;
        if (state_reg == S_WR)
            scr_mem[rc_addr] <= sum_reg;
        base_rd_a <= base_mem[a_addr];
        base_rd_b <= base_mem[b_addr];
        accm_rd   <= accm_mem[a_addr];
        scr_rd    <= scr_mem[rc_addr];
    end

    assign mac_start = (state_reg == S_RDW);

    lrmp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a      (mul_acc_reg ? accm_rd : base_rd_a),
        .b      (base_rd_b),
        .acc    (sum_reg),
        .done   (mac_done),
        .result (mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            order_reg     <= 5'd2;
            out_valid_reg <= 1'b0;
            r_reg <= '0;
            c_reg <= '0;
            t_reg <= '0;
            mul_acc_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                order_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        exp_reg   <= EXPONENT_BITS'(exponent);
                        m_reg     <= m_sat;
                        r_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    c_reg <= last_c ? '0 : c_reg + IW'(1);
                    if (last_c)
                    begin
                        r_reg <= last_r ? '0 : r_reg + IW'(1);
                        if (last_r)
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    r_reg   <= '0;
                    c_reg   <= '0;
                    t_reg   <= '0;
                    sum_reg <= '0;
                    if (exp_reg == '0)
                        state_reg <= S_OUT;
                    else
                    begin
                        mul_acc_reg <= exp_reg[0];
                        state_reg   <= S_RD;
                    end
                end
                S_RD:  state_reg <= S_RDW;
                S_RDW: state_reg <= S_MAC;
                S_MAC:
                begin
                    if (mac_done)
                    begin
                        sum_reg <= mac_res;
                        if (last_t)
                            state_reg <= S_WR;
                        else
                        begin
                            t_reg     <= t_reg + IW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_WR:
                begin
                    t_reg   <= '0;
                    sum_reg <= '0;
                    c_reg   <= last_c ? '0 : c_reg + IW'(1);
                    state_reg <= S_RD;
                    if (last_c)
                    begin
                        r_reg <= last_r ? '0 : r_reg + IW'(1);
                        if (last_r)
                            state_reg <= S_CPR;
                    end
                end
                S_CPR: state_reg <= S_CPW;
                S_CPW:
                begin
                    c_reg     <= last_c ? '0 : c_reg + IW'(1);
                    state_reg <= S_CPR;
                    if (last_c)
                    begin
                        r_reg <= last_r ? '0 : r_reg + IW'(1);
                        if (last_r)
                        begin
                            if (mul_acc_reg)
                            begin
                                mul_acc_reg <= 1'b0;
                                t_reg       <= '0;
                                sum_reg     <= '0;
                                state_reg   <= S_RD;
                            end
                            else
                            begin
                                exp_reg   <= exp_reg >> 1;
                                state_reg <= S_CHECK;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !out_valid_reg)
            res_reg <= accm_rd;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign count_mod_p = res_reg;

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("output valid outside output state");
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_mod_p < MODULUS) else $error("result not reduced");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_mod_p))
        else $error("stalled result changed");
endmodule
`default_nettype wire
